// ===== design/lmlt_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD mode and line timing - shared definitions
// Widths, timing lengths, register indexes and the display mode type.
// ----------------------------------------------------------------------------
package lmlt_pkg;

   localparam int VISIBLE_LINES = 144;
   localparam int TOTAL_LINES   = 154;

   localparam int LINE_W  = 8;
   localparam int CYC_W   = 8;
   localparam int ACC_W   = 10;
   localparam int MODE_W  = 2;
   localparam int CMP_W   = 8;
   localparam int STATE_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [ACC_W-1:0] HBLANK_LEN = ACC_W'(207);
   localparam logic [ACC_W-1:0] VBLANK_LEN = ACC_W'(456);
   localparam logic [ACC_W-1:0] OAM_LEN    = ACC_W'(83);
   localparam logic [ACC_W-1:0] XFER_LEN   = ACC_W'(175);
   localparam logic [ACC_W-1:0] ACC_MAX    = '1;

   localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(TOTAL_LINES - 1);
   localparam logic [LINE_W-1:0] VBL_LINE  = LINE_W'(VISIBLE_LINES);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LCD_ENABLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COMPARE_LINE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STAT_INT_EN  = 2'd2;

   // stat enable bit positions
   localparam int EN_HBLANK = 0;
   localparam int EN_VBLANK = 1;
   localparam int EN_OAM    = 2;

   // input item command
   localparam logic CMD_TICK       = 1'b0;
   localparam logic CMD_CLEAR_LINE = 1'b1;

   // reported mode codes
   localparam logic [MODE_W-1:0] PPU_HBLANK = 2'd0;
   localparam logic [MODE_W-1:0] PPU_VBLANK = 2'd1;
   localparam logic [MODE_W-1:0] PPU_OAM    = 2'd2;
   localparam logic [MODE_W-1:0] PPU_XFER   = 2'd3;

   typedef enum logic [3:0] {
      ST_HBLANK = 4'b0001,
      ST_VBLANK = 4'b0010,
      ST_OAM    = 4'b0100,
      ST_XFER   = 4'b1000
   } disp_state_type;

   function automatic logic [MODE_W-1:0] mode_code(input disp_state_type st);
      logic [MODE_W-1:0] code;
      case (st)
         ST_HBLANK: code = PPU_HBLANK;
         ST_VBLANK: code = PPU_VBLANK;
         ST_OAM:    code = PPU_OAM;
         ST_XFER:   code = PPU_XFER;
         default:   code = PPU_HBLANK;
      endcase
      return code;
   endfunction

endpackage

// ===== design/lcd_mode_line_timing.sv =====
// ----------------------------------------------------------------------------
// LCD mode and line timing
// Steps the display through oam scan, transfer, hblank and vblank from
// elapsed-cycle ticks; keeps the line counter and coincidence flag.
// ----------------------------------------------------------------------------
// The accumulator add, saturation, one length compare and subtract, and the
// line advance and compare all sit between the state registers and the
// result register, so a new item is taken every cycle unless req_stall holds
// it. The result register is taken up again in the same cycle it is
// emptied; req_stall is high only while a result waits and rsp_stall is high.
// Configuration writes go straight to the registers.
module lcd_mode_line_timing (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [lmlt_pkg::CYC_W-1:0]      req_elapsed_cycles,
   input  logic                            req_cpu_int_enabled,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lmlt_pkg::MODE_W-1:0]     rsp_ppu_mode,
   output logic [lmlt_pkg::LINE_W-1:0]     rsp_line,
   output logic                            rsp_coincidence,
   output logic                            rsp_vblank_irq,
   output logic                            rsp_stat_irq,
   output logic                            rsp_render_strobe,
   input  logic                            csr_we,
   input  logic [lmlt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lmlt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lmlt_pkg::*;

   logic                 lcd_enable_ff;
   logic [CMP_W-1:0]     compare_line_ff;
   logic [STATE_W-1:0]   stat_en_ff;

   logic [ACC_W-1:0]     acc_ff, acc_in;
   disp_state_type       state_ff, state_in;
   logic [LINE_W-1:0]    line_ff, line_in;
   logic                 coin_ff, coin_in;

   logic                 rsp_valid_ff;
   logic [MODE_W-1:0]    rsp_mode_ff;
   logic [LINE_W-1:0]    rsp_line_ff;
   logic                 rsp_coin_ff;
   logic                 rsp_vbl_ff, rsp_stat_ff, rsp_rend_ff;

   logic                 vbl_in, stat_in, rend_in;
   logic                 accept;
   logic                 enable_rise;
   logic [ACC_W:0]       sum;
   logic [ACC_W-1:0]     acc_sat;
   logic [LINE_W-1:0]    line_adv;
   logic                 adv_coin;
   logic                 ime;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign ime       = req_cpu_int_enabled;

   assign enable_rise = csr_we & (csr_index == REG_LCD_ENABLE) & csr_wdata[0] & ~lcd_enable_ff;

   assign sum      = {1'b0, acc_ff} + {{(ACC_W+1-CYC_W){1'b0}}, req_elapsed_cycles};
   assign acc_sat  = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
   assign line_adv = (line_ff == LAST_LINE) ? '0 : line_ff + LINE_W'(1);
   assign adv_coin = (line_adv == compare_line_ff);

   always_comb begin
      acc_in   = acc_ff;
      state_in = state_ff;
      line_in  = line_ff;
      coin_in  = coin_ff;
      vbl_in   = 1'b0;
      stat_in  = 1'b0;
      rend_in  = 1'b0;
      if (req_mode == CMD_CLEAR_LINE) begin
         line_in = '0;
      end else if (lcd_enable_ff) begin
         acc_in = acc_sat;
         case (state_ff)
            ST_HBLANK: begin
               if (acc_sat >= HBLANK_LEN) begin
                  acc_in  = acc_sat - HBLANK_LEN;
                  line_in = line_adv;
                  coin_in = adv_coin;
                  if (line_adv == VBL_LINE) begin
                     state_in = ST_VBLANK;
                     vbl_in   = 1'b1;
                     stat_in  = ime & (adv_coin | stat_en_ff[EN_VBLANK]);
                  end else begin
                     state_in = ST_OAM;
                     stat_in  = ime & (adv_coin | stat_en_ff[EN_OAM]);
                  end
               end
            end
            ST_VBLANK: begin
               if (acc_sat >= VBLANK_LEN) begin
                  acc_in  = acc_sat - VBLANK_LEN;
                  line_in = line_adv;
                  coin_in = adv_coin;
                  if (line_adv == '0) begin
                     state_in = ST_OAM;
                     stat_in  = ime & (adv_coin | stat_en_ff[EN_OAM]);
                  end else begin
                     stat_in  = ime & adv_coin;
                  end
               end
            end
            ST_OAM: begin
               if (acc_sat >= OAM_LEN) begin
                  acc_in   = acc_sat - OAM_LEN;
                  state_in = ST_XFER;
               end
            end
            ST_XFER: begin
               if (acc_sat >= XFER_LEN) begin
                  acc_in   = acc_sat - XFER_LEN;
                  state_in = ST_HBLANK;
                  rend_in  = 1'b1;
                  stat_in  = ime & stat_en_ff[EN_HBLANK];
               end
            end
            default: begin
               state_in = ST_HBLANK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_enable_ff   <= 1'b1;
         compare_line_ff <= '0;
         stat_en_ff      <= '0;
         acc_ff          <= '0;
         state_ff        <= ST_HBLANK;
         line_ff         <= '0;
         coin_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (enable_rise) begin
            acc_ff  <= '0;
            line_ff <= '0;
         end else if (accept) begin
            acc_ff  <= acc_in;
            line_ff <= line_in;
         end
         if (accept) begin
            state_ff <= state_in;
            coin_ff  <= coin_in;
         end
         if (csr_we) begin
            case (csr_index)
               REG_LCD_ENABLE:   lcd_enable_ff   <= csr_wdata[0];
               REG_COMPARE_LINE: compare_line_ff <= csr_wdata[CMP_W-1:0];
               REG_STAT_INT_EN:  stat_en_ff      <= csr_wdata[STATE_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (~rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_mode_ff <= mode_code(state_in);
         rsp_line_ff <= line_in;
         rsp_coin_ff <= coin_in;
         rsp_vbl_ff  <= vbl_in;
         rsp_stat_ff <= stat_in;
         rsp_rend_ff <= rend_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ppu_mode      = rsp_mode_ff;
   assign rsp_line          = rsp_line_ff;
   assign rsp_coincidence   = rsp_coin_ff;
   assign rsp_vblank_irq    = rsp_vbl_ff;
   assign rsp_stat_irq      = rsp_stat_ff;
   assign rsp_render_strobe = rsp_rend_ff;

endmodule

// ===== bench/tb_lcd_mode_line_timing.sv =====
// ----------------------------------------------------------------------------
// LCD mode and line timing - testbench
// Drives ticks and line-clear commands through the valid/stall request
// channel and holds its own model of the mode, line, accumulator and
// coincidence state. Each result item is checked field by field against the
// oldest predicted one. Both channels idle and stall at random; the registers
// are rewritten only when nothing is outstanding.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_lcd_mode_line_timing;
   import lmlt_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [MODE_W-1:0] ppu_mode;
      logic [LINE_W-1:0] line;
      logic              coincidence;
      logic              vblank_irq;
      logic              stat_irq;
      logic              render_strobe;
   } line_status_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_mode = CMD_TICK;
   logic [CYC_W-1:0]      req_elapsed_cycles = '0;
   logic                  req_cpu_int_enabled = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [MODE_W-1:0]     rsp_ppu_mode;
   logic [LINE_W-1:0]     rsp_line;
   logic                  rsp_coincidence;
   logic                  rsp_vblank_irq;
   logic                  rsp_stat_irq;
   logic                  rsp_render_strobe;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // model state and registers
   logic [ACC_W-1:0]  acc_m      = '0;
   logic [MODE_W-1:0] disp_mode_m = PPU_HBLANK;
   logic [LINE_W-1:0] line_m     = '0;
   logic              coin_m     = 1'b0;
   logic              lcd_on_m   = 1'b1;
   logic [CMP_W-1:0]  cmp_line_m = '0;
   logic [2:0]        stat_en_m  = '0;

   line_status_type pending_status_q[$];
   int err_count   = 0;
   int burst_left  = 0;
   int stall_cnt   = 0;
   int idle_cycles = 0;

   lcd_mode_line_timing dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_elapsed_cycles  (req_elapsed_cycles),
      .req_cpu_int_enabled (req_cpu_int_enabled),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_ppu_mode        (rsp_ppu_mode),
      .rsp_line            (rsp_line),
      .rsp_coincidence     (rsp_coincidence),
      .rsp_vblank_irq      (rsp_vblank_irq),
      .rsp_stat_irq        (rsp_stat_irq),
      .rsp_render_strobe   (rsp_render_strobe),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CYC_W-1:0] rand_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return '1;
      if (r < 20) return '0;
      if (r < 35) return CYC_W'($urandom_range(0, 15));
      return CYC_W'($urandom_range(0, 255));
   endfunction

   function automatic logic rand_ime();
      return $urandom_range(0, 3) != 0;
   endfunction

   function automatic void advance_line_m();
      line_m = LINE_W'((int'(line_m) + 1) % TOTAL_LINES);
      coin_m = (line_m == cmp_line_m);
   endfunction

   function automatic logic mode_irq_m(input logic ime);
      logic en;
      case (disp_mode_m)
         PPU_HBLANK: en = stat_en_m[EN_HBLANK];
         PPU_VBLANK: en = stat_en_m[EN_VBLANK];
         PPU_OAM:    en = stat_en_m[EN_OAM];
         default:    en = 1'b0;
      endcase
      return en && ime;
   endfunction

   function automatic line_status_type predict_timing(input logic cmd,
                                                      input logic [CYC_W-1:0] cyc,
                                                      input logic ime);
      line_status_type r;
      int sum;
      logic vbl, stat, rend;
      vbl  = 1'b0;
      stat = 1'b0;
      rend = 1'b0;
      if (cmd == CMD_CLEAR_LINE) begin
         line_m = '0;
      end else if (lcd_on_m) begin
         sum = int'(acc_m) + int'(cyc);
         if (sum > int'(ACC_MAX)) sum = int'(ACC_MAX);
         acc_m = ACC_W'(sum);
         case (disp_mode_m)
            PPU_HBLANK: begin
               if (acc_m >= HBLANK_LEN) begin
                  acc_m = acc_m - HBLANK_LEN;
                  advance_line_m();
                  if (coin_m && ime) stat = 1'b1;
                  if (line_m == VBL_LINE) begin
                     disp_mode_m = PPU_VBLANK;
                     vbl = 1'b1;
                  end else begin
                     disp_mode_m = PPU_OAM;
                  end
                  if (mode_irq_m(ime)) stat = 1'b1;
               end
            end
            PPU_VBLANK: begin
               if (acc_m >= VBLANK_LEN) begin
                  acc_m = acc_m - VBLANK_LEN;
                  advance_line_m();
                  if (coin_m && ime) stat = 1'b1;
                  if (line_m == '0) begin
                     disp_mode_m = PPU_OAM;
                     if (mode_irq_m(ime)) stat = 1'b1;
                  end
               end
            end
            PPU_OAM: begin
               if (acc_m >= OAM_LEN) begin
                  acc_m = acc_m - OAM_LEN;
                  disp_mode_m = PPU_XFER;
               end
            end
            default: begin
               if (acc_m >= XFER_LEN) begin
                  acc_m = acc_m - XFER_LEN;
                  rend = 1'b1;
                  disp_mode_m = PPU_HBLANK;
                  if (mode_irq_m(ime)) stat = 1'b1;
               end
            end
         endcase
      end
      r.ppu_mode      = disp_mode_m;
      r.line          = line_m;
      r.coincidence   = coin_m;
      r.vblank_irq    = vbl;
      r.stat_irq      = stat;
      r.render_strobe = rend;
      return r;
   endfunction

   task automatic send_item(input logic cmd, input logic [CYC_W-1:0] cyc, input logic ime);
      int gap;
      req_valid           <= 1'b1;
      req_mode            <= cmd;
      req_elapsed_cycles  <= cyc;
      req_cpu_int_enabled <= ime;
      do @(posedge clock); while (req_stall);
      pending_status_q.push_back(predict_timing(cmd, cyc, ime));
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = idle_len();
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every outstanding item has come back
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_status_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_LCD_ENABLE: begin
            if (data[0] && !lcd_on_m) begin
               line_m = '0;
               acc_m  = '0;
            end
            lcd_on_m = data[0];
         end
         REG_COMPARE_LINE: cmp_line_m = data;
         REG_STAT_INT_EN:  stat_en_m  = data[2:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_item(CMD_TICK, '0, 1'b0);
      send_item(CMD_TICK, 8'd100, 1'b1);
   endtask

   // one line walked through by hand, then saturation and line clears
   task automatic test_mode_sequence();
      wait_drain();
      write_reg(REG_STAT_INT_EN, 8'hFF);
      write_reg(REG_COMPARE_LINE, 8'd1);
      send_item(CMD_TICK, 8'd106, 1'b1);
      send_item(CMD_TICK, 8'd1, 1'b1);
      send_item(CMD_TICK, 8'd82, 1'b0);
      send_item(CMD_TICK, 8'd1, 1'b0);
      send_item(CMD_TICK, 8'd175, 1'b1);
      repeat (11) send_item(CMD_TICK, 8'hFF, 1'b1);
      send_item(CMD_CLEAR_LINE, 8'hFF, 1'b1);
      send_item(CMD_CLEAR_LINE, 8'h00, 1'b0);
      send_item(CMD_TICK, '0, 1'b1);
   endtask

   task automatic test_display_off();
      wait_drain();
      write_reg(REG_LCD_ENABLE, 8'hFE);
      send_item(CMD_TICK, 8'hFF, 1'b1);
      send_item(CMD_TICK, 8'h55, 1'b0);
      send_item(CMD_CLEAR_LINE, 8'hAA, 1'b1);
      wait_drain();
      write_reg(REG_LCD_ENABLE, 8'h01);
      write_reg(REG_SPARE, 8'hFF);
      write_reg(REG_STAT_INT_EN, 8'h00);
      write_reg(REG_COMPARE_LINE, 8'h00);
      send_item(CMD_TICK, '0, 1'b0);
      send_item(CMD_TICK, 8'hFF, 1'b1);
   endtask

   // long runs of ticks so that frames wrap through vblank
   task automatic test_frame_timing();
      logic [CMP_W-1:0] cmp;
      logic [2:0] en;
      for (int seg = 0; seg < 4; seg++) begin
         wait_drain();
         case (seg)
            0: begin cmp = 8'd0;   en = 3'b111; end
            1: begin cmp = 8'd153; en = 3'($urandom); end
            2: begin cmp = 8'd255; en = 3'b000; end
            default: begin
               cmp = CMP_W'($urandom_range(0, TOTAL_LINES - 1));
               en  = 3'($urandom);
            end
         endcase
         write_reg(REG_COMPARE_LINE, cmp);
         write_reg(REG_STAT_INT_EN, {5'($urandom), en});
         for (int n = 0; n < 335; n++) begin
            if (n % 100 == 0) burst_left = 30;
            if (n % 100 == 70) wait_drain();
            send_item(CMD_TICK, rand_cycles(), rand_ime());
         end
      end
   endtask

   // clears mixed in, and the display switched off and back on
   task automatic test_line_clear_noise();
      logic cmd;
      for (int seg = 0; seg < 4; seg++) begin
         wait_drain();
         write_reg(REG_LCD_ENABLE, {7'($urandom), (seg == 1) ? 1'b0 : 1'b1});
         write_reg(REG_COMPARE_LINE, CMP_W'($urandom_range(0, 20)));
         write_reg(REG_STAT_INT_EN, CSR_DATA_W'($urandom));
         for (int n = 0; n < 60; n++) begin
            cmd = ($urandom_range(0, 99) < 15) ? CMD_CLEAR_LINE : CMD_TICK;
            send_item(cmd, CYC_W'($urandom), rand_ime());
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_mode_sequence();
      test_display_off();
      test_frame_timing();
      test_line_clear_noise();
      wait_drain();
      repeat (8) @(posedge clock);
      if (err_count == 0 && pending_status_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_cnt <= 0;
      end else if (stall_cnt != 0) begin
         stall_cnt <= stall_cnt - 1;
      end else if (!rsp_stall && $urandom_range(0, 99) < 40) begin
         rsp_stall <= 1'b1;
         stall_cnt <= idle_len();
      end else begin
         rsp_stall <= 1'b0;
         stall_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 8);
      end
   end

   always @(posedge clock) begin
      line_status_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status_q.size() == 0) begin
            $error("result item with no item outstanding");
            err_count++;
         end else begin
            exp_r = pending_status_q.pop_front();
            if (rsp_ppu_mode !== exp_r.ppu_mode) begin
               $error("ppu_mode: expected %0d, got %0d", exp_r.ppu_mode, rsp_ppu_mode);
               err_count++;
            end
            if (rsp_line !== exp_r.line) begin
               $error("line: expected %0d, got %0d", exp_r.line, rsp_line);
               err_count++;
            end
            if (rsp_coincidence !== exp_r.coincidence) begin
               $error("coincidence: expected %0b, got %0b",
                      exp_r.coincidence, rsp_coincidence);
               err_count++;
            end
            if (rsp_vblank_irq !== exp_r.vblank_irq) begin
               $error("vblank_irq: expected %0b, got %0b", exp_r.vblank_irq, rsp_vblank_irq);
               err_count++;
            end
            if (rsp_stat_irq !== exp_r.stat_irq) begin
               $error("stat_irq: expected %0b, got %0b", exp_r.stat_irq, rsp_stat_irq);
               err_count++;
            end
            if (rsp_render_strobe !== exp_r.render_strobe) begin
               $error("render_strobe: expected %0b, got %0b",
                      exp_r.render_strobe, rsp_render_strobe);
               err_count++;
            end
         end
      end
   end

   // watchdog: cycles with no handshake and no register write
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
